// ----- rtl/core/uec_pkg.sv -----
package uec_pkg;

    localparam int COUNT_WIDTH_DEF = 12;
    localparam int TOTAL_W         = 12;
    localparam int ACC_W           = 21;

    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;
    localparam logic [7:0] CONT_BITS  = 8'h3F;

    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_ONE  = 2'd1;
    localparam logic [1:0] PEND_TWO  = 2'd2;
    localparam logic [1:0] PEND_THREE = 2'd3;

    localparam logic [ACC_W-1:0] PICT_LO = 21'h1F300;
    localparam logic [ACC_W-1:0] PICT_HI = 21'h1FAFF;
    localparam logic [ACC_W-1:0] MISC_LO = 21'h02600;
    localparam logic [ACC_W-1:0] MISC_HI = 21'h027BF;
    localparam logic [ACC_W-1:0] FLAG_LO = 21'h1F1E6;
    localparam logic [ACC_W-1:0] FLAG_HI = 21'h1F1FF;

    // per-byte decode outcome handed to the tally
    typedef struct packed {
        logic hit;
        logic last;
    } t_dec;

    function automatic logic is_emoji(input logic [ACC_W-1:0] cp);
        is_emoji = (cp >= PICT_LO && cp <= PICT_HI) ||
                   (cp >= MISC_LO && cp <= MISC_HI) ||
                   (cp >= FLAG_LO && cp <= FLAG_HI);
    endfunction

endpackage

// ----- rtl/core/uec_decoder.sv -----
module uec_decoder
    import uec_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_dec       o_dec
);

    logic [1:0]       r_pend, n_pend;
    logic [ACC_W-1:0] r_acc, n_acc;
    logic [ACC_W-1:0] acc_shift;
    logic             hit;

    assign acc_shift = {r_acc[ACC_W-7:0], i_byte[5:0] & CONT_BITS[5:0]};

    always_comb begin
        n_pend = r_pend;
        n_acc  = r_acc;
        hit    = 1'b0;
        if (r_pend == PEND_NONE) begin
            if ((i_byte & LEAD2_MASK) == LEAD2_CODE) begin
                n_pend = PEND_ONE;
                n_acc  = ACC_W'(i_byte[4:0]);
            end else if ((i_byte & LEAD3_MASK) == LEAD3_CODE) begin
                n_pend = PEND_TWO;
                n_acc  = ACC_W'(i_byte[3:0]);
            end else if ((i_byte & LEAD4_MASK) == LEAD4_CODE) begin
                n_pend = PEND_THREE;
                n_acc  = ACC_W'(i_byte[2:0]);
            end
        end else if ((i_byte & CONT_MASK) != CONT_CODE) begin
            // broken sequence, drop it together with this byte
            n_pend = PEND_NONE;
            n_acc  = '0;
        end else begin
            n_pend = r_pend - 2'd1;
            if (r_pend == PEND_ONE) begin
                hit   = is_emoji(acc_shift);
                n_acc = '0;
            end else begin
                n_acc = acc_shift;
            end
        end
        // end of message clears any open sequence
        if (i_last) begin
            n_pend = PEND_NONE;
            n_acc  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= PEND_NONE;
            r_acc  <= '0;
        end else if (i_step) begin
            r_pend <= n_pend;
            r_acc  <= n_acc;
        end
    end

    assign o_dec.hit  = hit;
    assign o_dec.last = i_last;

endmodule

// ----- rtl/core/uec_tally.sv -----
module uec_tally
    import uec_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  t_dec               i_dec,
    input  logic               i_out_ready,
    output logic               o_out_free,
    output logic               o_out_valid,
    output logic [TOTAL_W-1:0] o_emoji_total,
    output logic               o_count_saturated
);

    localparam logic [COUNT_WIDTH-1:0] TALLY_MAX = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0] r_tally, n_tally;
    logic                   r_full, n_full;
    logic                   r_out_valid;
    logic [TOTAL_W-1:0]     r_total;
    logic                   r_sat;

    always_comb begin
        n_tally = r_tally;
        if (i_dec.hit && r_tally != TALLY_MAX) begin
            n_tally = r_tally + COUNT_WIDTH'(1);
        end
        n_full = r_full || (n_tally == TALLY_MAX);
    end

    assign o_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tally     <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_step) begin
                if (i_dec.last) begin
                    r_tally     <= '0;
                    r_full      <= 1'b0;
                    r_out_valid <= 1'b1;
                end else begin
                    r_tally <= n_tally;
                    r_full  <= n_full;
                end
            end
        end
    end

    // result payload, loaded only when the output slot is free
    always_ff @(posedge i_clk) begin
        if (i_step && i_dec.last) begin
            r_total <= TOTAL_W'(n_tally);
            r_sat   <= n_full;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_emoji_total     = r_total;
    assign o_count_saturated = r_sat;

endmodule

// ----- rtl/core/utf8_emoji_counter_unit.sv -----
// Counts emoji code points in a UTF-8 message streamed one byte per request,
// with i_last_byte on the final byte. One byte is taken every cycle when the
// output side keeps up; a message's last byte is registered in the input
// stage, then its result is loaded into the output register once the slot is
// free and holds there until taken, while the next message's bytes keep flowing
// up to its own last byte. The rate is set by the decode state update (sequence
// count, code point accumulator and tally). The count saturates at
// 2**COUNT_WIDTH - 1 and is shown in 12 bits.
module utf8_emoji_counter_unit
    import uec_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [TOTAL_W-1:0] o_emoji_total,
    output logic               o_count_saturated
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       out_free;
    logic       step;
    t_dec       dec;

    // a last byte must wait for the result slot, other bytes never stall
    assign step       = r_in_valid && (!r_in_last || out_free);
    assign o_in_ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    uec_decoder u_decoder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_dec   (dec)
    );

    uec_tally #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_tally (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step            (step),
        .i_dec             (dec),
        .i_out_ready       (i_out_ready),
        .o_out_free        (out_free),
        .o_out_valid       (o_out_valid),
        .o_emoji_total     (o_emoji_total),
        .o_count_saturated (o_count_saturated)
    );

endmodule

// ----- rtl/core/uec_checker.sv -----
module uec_checker
    import uec_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic [7:0]         i_data_byte,
    input logic               i_last_byte,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [TOTAL_W-1:0] o_emoji_total,
    input logic               o_count_saturated
);

    localparam logic [TOTAL_W-1:0] SHOWN_MAX = TOTAL_W'((1 << COUNT_WIDTH) - 1);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_emoji_total) && $stable(o_count_saturated))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // saturation flag only with the maximum count
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_count_saturated |-> o_emoji_total == SHOWN_MAX)
        else $error("saturated flag without maximum count");

    a_max_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_count_saturated |->
            (COUNT_WIDTH > TOTAL_W) || (o_emoji_total != SHOWN_MAX))
        else $error("maximum count without saturated flag");

    // the input stalls only while a result is stuck in the output register
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled with free result slot");

endmodule

bind utf8_emoji_counter_unit uec_checker #(.COUNT_WIDTH(COUNT_WIDTH)) u_uec_checker (.*);
